// ----- sv/fifo_readers_writer_lock_assert.svh -----
// Assertion macros for the readers-writer lock block.
`ifndef FIFO_READERS_WRITER_LOCK_ASSERT_SVH
`define FIFO_READERS_WRITER_LOCK_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, clocked on clk, disabled while rst_n is low.
`define FRWL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled while rst_n is low.
`define FRWL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FRWL_ASSERT_SAME(label, ante, cons, msg)
`define FRWL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- sv/frwl_pkg.sv -----
// Shared types and constants of the readers-writer lock block.
package frwl_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 6;

    localparam int MODE_W    = 3;
    localparam int OUTCOME_W = 3;
    localparam int ERROR_W   = 2;

    // Readers woken by one write release at most.
    localparam int MAX_RESULTS = 16;

    localparam int               READER_W   = 7;
    localparam logic [READER_W-1:0] READER_MAX = 7'd127;

    // Command queue between front and back.
    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [MODE_W-1:0] {
        OP_RD_ACQ = 3'd0,
        OP_RD_REL = 3'd1,
        OP_WR_ACQ = 3'd2,
        OP_WR_REL = 3'd3,
        OP_TRY_RD = 3'd4
    } op_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_GRANTED  = 3'd0,
        OUT_QUEUED   = 3'd1,
        OUT_REFUSED  = 3'd2,
        OUT_WOKEN    = 3'd3,
        OUT_RELEASED = 3'd4
    } outcome_t;

    typedef enum logic [ERROR_W-1:0] {
        ERR_OK         = 2'd0,
        ERR_QUEUE_FULL = 2'd1,
        ERR_NOT_HELD   = 2'd2,
        ERR_WRONG_KIND = 2'd3
    } error_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_WAKE
    } state_t;

    // Command handed from front to back (requester id travels beside it).
    typedef struct packed {
        logic valid;
        op_t  op;
    } cmd_ctl_t;

endpackage

// ----- sv/frwl_front.sv -----
// Front end: accepts requests, drops undefined modes, queues commands.
module frwl_front #(
    parameter int ID_BITS = frwl_pkg::ID_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [frwl_pkg::MODE_W-1:0]  in_mode,
    input  logic [ID_BITS-1:0]           in_requester,
    output frwl_pkg::cmd_ctl_t           cmd,
    output logic [ID_BITS-1:0]           cmd_req,
    input  logic                         cmd_pop
);
    import frwl_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    op_t                op_q  [CMDQ_DEPTH];
    logic [ID_BITS-1:0] req_q [CMDQ_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic mode_ok;
    logic push;

    always_comb
    begin
        unique case (in_mode) inside
            OP_RD_ACQ, OP_RD_REL, OP_WR_ACQ, OP_WR_REL, OP_TRY_RD: mode_ok = 1'b1;
            default:                                               mode_ok = 1'b0;
        endcase
    end

    assign in_ready = (cnt_reg != CNT_W'(CMDQ_DEPTH));
    // Undefined modes are taken and dropped here.
    assign push     = in_valid && in_ready && mode_ok;

    assign cmd     = {(cnt_reg != '0), op_q[rd_ptr_reg]};
    assign cmd_req = req_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q[wr_ptr_reg]  <= op_t'(in_mode);
            req_q[wr_ptr_reg] <= in_requester;
        end
    end

endmodule

// ----- sv/frwl_back.sv -----
// Back end: lock state, wait queue memory, sequencer and result register.
module frwl_back #(
    parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = frwl_pkg::ID_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  frwl_pkg::cmd_ctl_t             cmd,
    input  logic [ID_BITS-1:0]             cmd_req,
    output logic                           cmd_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ID_BITS-1:0]             out_who,
    output logic [frwl_pkg::OUTCOME_W-1:0] out_outcome,
    output logic [frwl_pkg::ERROR_W-1:0]   out_error,
    output logic                           out_last
);
    import frwl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = ID_BITS + 1;
    localparam int WN_W  = $clog2(MAX_RESULTS + 1);

    logic [ENT_W-1:0] wq_mem [QUEUE_DEPTH];

    state_t             state_reg, state_next;
    op_t                op_reg;
    logic [ID_BITS-1:0] req_reg;
    logic [ENT_W-1:0]   head_ent_reg;
    logic [READER_W-1:0] readers_reg, readers_next;
    logic               writer_reg, writer_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ID_BITS-1:0] pend_who_reg;
    logic [WN_W-1:0]    wake_n_reg, wake_n_next;

    logic               out_valid_reg;
    logic [ID_BITS-1:0] out_who_reg;
    outcome_t           out_outcome_reg;
    error_t             out_error_reg;
    logic               out_last_reg;

    logic out_room, q_empty, q_full, hd_writer, to_wake, wake_more;

    // Sequencer controls.
    logic               emit;
    logic [ID_BITS-1:0] emit_who;
    outcome_t           emit_outcome;
    error_t             emit_error;
    logic               emit_last;
    logic               rd_inc, rd_dec, wr_set, wr_clr;
    logic               enq, enq_writer, deq;
    logic               pend_load, wake_clr, wake_inc;

    assign out_room  = !out_valid_reg || out_ready;
    assign q_empty   = (count_reg == '0);
    assign q_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign hd_writer = head_ent_reg[ID_BITS];
    assign to_wake   = (op_reg == OP_WR_REL) && writer_reg && !q_empty && !hd_writer;
    assign wake_more = !q_empty && !hd_writer && (wake_n_reg < WN_W'(MAX_RESULTS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_room)
                begin
                    state_next = to_wake ? ST_READ : ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_WAKE;
            end
            ST_WAKE:
            begin
                if (out_room)
                begin
                    state_next = wake_more ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop      = 1'b0;
        emit         = 1'b0;
        emit_who     = req_reg;
        emit_outcome = OUT_GRANTED;
        emit_error   = ERR_OK;
        emit_last    = 1'b1;
        rd_inc       = 1'b0;
        rd_dec       = 1'b0;
        wr_set       = 1'b0;
        wr_clr       = 1'b0;
        enq          = 1'b0;
        enq_writer   = 1'b0;
        deq          = 1'b0;
        pend_load    = 1'b0;
        wake_clr     = 1'b0;
        wake_inc     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_pop = cmd.valid;
            end
            ST_EXEC:
            begin
                if (out_room)
                begin
                    emit = 1'b1;
                    unique case (op_reg) inside
                        OP_RD_ACQ, OP_TRY_RD:
                        begin
                            if (!writer_reg && q_empty)
                            begin
                                rd_inc = 1'b1;
                            end
                            else if (op_reg == OP_TRY_RD)
                            begin
                                emit_outcome = OUT_REFUSED;
                            end
                            else if (!q_full)
                            begin
                                enq          = 1'b1;
                                emit_outcome = OUT_QUEUED;
                            end
                            else
                            begin
                                emit_outcome = OUT_REFUSED;
                                emit_error   = ERR_QUEUE_FULL;
                            end
                        end
                        OP_RD_REL:
                        begin
                            if (readers_reg == '0)
                            begin
                                emit_outcome = OUT_REFUSED;
                                emit_error   = ERR_NOT_HELD;
                            end
                            else
                            begin
                                rd_dec = 1'b1;
                                if (readers_reg != READER_W'(1) || q_empty)
                                begin
                                    emit_outcome = OUT_RELEASED;
                                end
                                else if (!hd_writer)
                                begin
                                    emit_outcome = OUT_RELEASED;
                                    emit_error   = ERR_WRONG_KIND;
                                end
                                else
                                begin
                                    deq          = 1'b1;
                                    wr_set       = 1'b1;
                                    emit_who     = head_ent_reg[ID_BITS-1:0];
                                    emit_outcome = OUT_WOKEN;
                                end
                            end
                        end
                        OP_WR_ACQ:
                        begin
                            if (readers_reg == '0 && !writer_reg)
                            begin
                                wr_set = 1'b1;
                            end
                            else if (!q_full)
                            begin
                                enq          = 1'b1;
                                enq_writer   = 1'b1;
                                emit_outcome = OUT_QUEUED;
                            end
                            else
                            begin
                                emit_outcome = OUT_REFUSED;
                                emit_error   = ERR_QUEUE_FULL;
                            end
                        end
                        OP_WR_REL:
                        begin
                            if (!writer_reg)
                            begin
                                emit_outcome = OUT_REFUSED;
                                emit_error   = ERR_NOT_HELD;
                            end
                            else if (q_empty)
                            begin
                                wr_clr       = 1'b1;
                                emit_outcome = OUT_RELEASED;
                            end
                            else if (hd_writer)
                            begin
                                deq          = 1'b1;
                                emit_who     = head_ent_reg[ID_BITS-1:0];
                                emit_outcome = OUT_WOKEN;
                            end
                            else
                            begin
                                // First reader: hold it until the next head is known.
                                emit      = 1'b0;
                                deq       = 1'b1;
                                rd_inc    = 1'b1;
                                pend_load = 1'b1;
                                wake_clr  = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                emit = 1'b0;
            end
            ST_WAKE:
            begin
                if (out_room)
                begin
                    emit         = 1'b1;
                    emit_who     = pend_who_reg;
                    emit_outcome = OUT_WOKEN;
                    if (wake_more)
                    begin
                        emit_last = 1'b0;
                        deq       = 1'b1;
                        rd_inc    = 1'b1;
                        pend_load = 1'b1;
                        wake_inc  = 1'b1;
                    end
                    else
                    begin
                        wr_clr = 1'b1;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        readers_next = readers_reg;
        if (rd_inc && readers_reg != READER_MAX)
        begin
            readers_next = readers_reg + 1'b1;
        end
        else if (rd_dec)
        begin
            readers_next = readers_reg - 1'b1;
        end

        writer_next = writer_reg;
        if (wr_set)
        begin
            writer_next = 1'b1;
        end
        else if (wr_clr)
        begin
            writer_next = 1'b0;
        end

        head_next = head_reg;
        if (deq)
        begin
            head_next = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        tail_next = tail_reg;
        if (enq)
        begin
            tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        count_next = count_reg;
        if (enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq)
        begin
            count_next = count_reg - 1'b1;
        end

        wake_n_next = wake_n_reg;
        if (wake_clr)
        begin
            wake_n_next = WN_W'(1);
        end
        else if (wake_inc)
        begin
            wake_n_next = wake_n_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            readers_reg   <= '0;
            writer_reg    <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            wake_n_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            readers_reg <= readers_next;
            writer_reg  <= writer_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            wake_n_reg  <= wake_n_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and wait queue memory.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            op_reg  <= cmd.op;
            req_reg <= cmd_req;
        end
        if (pend_load)
        begin
            pend_who_reg <= head_ent_reg[ID_BITS-1:0];
        end
        if (emit)
        begin
            out_who_reg     <= emit_who;
            out_outcome_reg <= emit_outcome;
            out_error_reg   <= emit_error;
            out_last_reg    <= emit_last;
        end
        if (enq)
        begin
            wq_mem[tail_reg] <= {enq_writer, req_reg};
        end
        head_ent_reg <= wq_mem[head_reg];
    end

    assign out_valid   = out_valid_reg;
    assign out_who     = out_who_reg;
    assign out_outcome = out_outcome_reg;
    assign out_error   = out_error_reg;
    assign out_last    = out_last_reg;

endmodule

// ----- sv/fifo_readers_writer_lock.sv -----
// Top level of the readers-writer lock manager with a FIFO of waiters.
//
//  Port group | Dir | Contents                                      | Transfer when
//  -----------+-----+-----------------------------------------------+----------------------
//  s_*        | in  | tdata: mode, requester                         | s_tvalid && s_tready
//  m_*        | out | tdata: who, outcome, error; tlast: last        | m_tvalid && m_tready
//
// A request passes through the back-end sequencer's pop state, which also reads
// the wait queue head, and then its execute state, which loads the result register.
// In a write release that wakes readers, each reader costs a registered read of
// the wait queue memory and a wake step.
// Reset clears all control state at once; the wait queue memory is not cleared
// and its contents are only used at occupied entries, so requests are taken right after reset.
// A stalled m_tready holds the sequencer; the two-entry command queue keeps
// s_tready high until it fills.
module fifo_readers_writer_lock #(
    parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = frwl_pkg::ID_BITS_DEF,
    localparam int S_DATA_W   = ((frwl_pkg::MODE_W + ID_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   =
        ((ID_BITS + frwl_pkg::OUTCOME_W + frwl_pkg::ERROR_W + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // mode, requester (from bit 0 up)
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // who, outcome, error (from bit 0 up)
    output logic                m_tlast
);
    import frwl_pkg::*;

`include "fifo_readers_writer_lock_assert.svh"

    logic [MODE_W-1:0]    in_mode;
    logic [ID_BITS-1:0]   in_requester;
    cmd_ctl_t             cmd;
    logic [ID_BITS-1:0]   cmd_req;
    logic                 cmd_pop;
    logic [ID_BITS-1:0]   res_who;
    logic [OUTCOME_W-1:0] res_outcome;
    logic [ERROR_W-1:0]   res_error;

    // Unpack the request transfer.
    assign in_mode      = s_tdata[MODE_W-1:0];
    assign in_requester = s_tdata[MODE_W +: ID_BITS];

    // Front: take requests, drop undefined modes, queue commands.
    frwl_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_mode      (in_mode),
        .in_requester (in_requester),
        .cmd          (cmd),
        .cmd_req      (cmd_req),
        .cmd_pop      (cmd_pop)
    );

    // Back: run each command against the lock state and wait queue.
    frwl_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cmd_req     (cmd_req),
        .cmd_pop     (cmd_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_who     (res_who),
        .out_outcome (res_outcome),
        .out_error   (res_error),
        .out_last    (m_tlast)
    );

    // Pack the result transfer, zero fill to whole bytes.
    assign m_tdata = M_DATA_W'({res_error, res_outcome, res_who});

    // Back never pops an empty command queue.
    `FRWL_ASSERT_SAME(a_pop_needs_cmd, cmd_pop, cmd.valid, "command popped while queue empty")
    // Front stalls only when it holds commands for the back.
    `FRWL_ASSERT_SAME(a_stall_means_cmd, !s_tready, cmd.valid, "front stalled with no command")
    // Every command passes through the execute state before the next pop.
    `FRWL_ASSERT_NEXT(a_pop_spacing, cmd_pop, !cmd_pop, "back popped commands back to back")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the readers-writer lock block with its queue of waiters.
module tb;
    import frwl_pkg::*;

    localparam int S_W = ((MODE_W + ID_BITS_DEF + 7) / 8) * 8;
    localparam int M_W = ((ID_BITS_DEF + OUTCOME_W + ERROR_W + 7) / 8) * 8;

    // Mode codes the block must ignore.
    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;

    // Waiter entry: kind flag above the id, set for a writer.
    localparam int KIND_BIT = ID_BITS_DEF;

    localparam int STALL_LIMIT   = 2000;  // cycles without any transfer
    localparam int HOLDOFF_LEN   = 300;   // long receiver stall
    localparam int IDLE_PCT      = 22;
    localparam int GENERAL_ITEMS = 220;
    localparam int SATURATE_ITEMS = 132;
    localparam int TAIL_CYCLES   = 60;
    localparam int OPENING_LEN   = 14;

    typedef struct packed {
        logic [ID_BITS_DEF-1:0] who;
        outcome_t               outcome;
        error_t                 error;
        logic                   last;
    } answer_t;

    typedef struct {
        logic [MODE_W-1:0]      mode;
        logic [ID_BITS_DEF-1:0] id;
        bit                     typed;    // expectation written out below
        outcome_t               outcome;
        error_t                 error;
    } opening_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [S_W-1:0]     s_tdata;   // mode, requester (from bit 0 up)
    logic               m_tvalid;
    logic               m_tready;
    logic [M_W-1:0]     m_tdata;   // who, outcome, error (from bit 0 up)
    logic               m_tlast;

    // Lock state as the block should hold it.
    logic [READER_W-1:0]    rd_count = '0;
    logic                   wr_held  = 1'b0;
    logic [KIND_BIT:0]      waiters [QUEUE_DEPTH_DEF];
    logic [3:0]             wq_head  = '0;
    logic [3:0]             wq_tail  = '0;
    logic [4:0]             wq_count = '0;

    answer_t due_answers [$];
    int      fault_count = 0;
    bit      feed_calm   = 1'b0;

    // Opening script: reset faults, ignored codes, both kinds of waiter, a read
    // release that wakes a writer and a write release that wakes a reader.
    opening_row_t opening_rows [OPENING_LEN] = '{
        '{OP_RD_REL,     6'd0,  1'b1, OUT_REFUSED, ERR_NOT_HELD},
        '{OP_WR_REL,     6'd63, 1'b1, OUT_REFUSED, ERR_NOT_HELD},
        '{OP_TRY_RD,     6'd63, 1'b1, OUT_GRANTED, ERR_OK},
        '{MODE_UNDEF_LO, 6'd21, 1'b0, OUT_GRANTED, ERR_OK},
        '{MODE_UNDEF_HI, 6'd42, 1'b0, OUT_GRANTED, ERR_OK},
        '{OP_WR_ACQ,     6'd1,  1'b0, OUT_GRANTED, ERR_OK},
        '{OP_RD_ACQ,     6'd2,  1'b0, OUT_GRANTED, ERR_OK},
        '{OP_TRY_RD,     6'd3,  1'b0, OUT_GRANTED, ERR_OK},
        '{OP_RD_REL,     6'd63, 1'b0, OUT_GRANTED, ERR_OK},
        '{OP_WR_ACQ,     6'd4,  1'b0, OUT_GRANTED, ERR_OK},
        '{OP_WR_REL,     6'd1,  1'b0, OUT_GRANTED, ERR_OK},
        '{OP_RD_REL,     6'd2,  1'b0, OUT_GRANTED, ERR_OK},
        '{OP_WR_REL,     6'd4,  1'b0, OUT_GRANTED, ERR_OK},
        '{OP_WR_ACQ,     6'd0,  1'b0, OUT_GRANTED, ERR_OK}
    };

    fifo_readers_writer_lock dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic void answer(logic [ID_BITS_DEF-1:0] who, outcome_t oc, error_t er);
        due_answers.push_back('{who: who, outcome: oc, error: er, last: 1'b0});
    endfunction

    function automatic void bump_readers();
        if (rd_count != READER_MAX)
            rd_count++;
    endfunction

    function automatic void push_waiter(logic [KIND_BIT:0] entry);
        waiters[wq_tail] = entry;
        wq_tail++;
        wq_count++;
    endfunction

    function automatic void drop_head();
        wq_head++;
        wq_count--;
    endfunction

    // Advance the lock state by one request and queue the answers it owes.
    function automatic void apply_lock_request(logic [MODE_W-1:0] mode,
                                               logic [ID_BITS_DEF-1:0] id);
        int                woke;
        int                first;
        logic [KIND_BIT:0] head;
        answer_t           tail_ans;
        woke  = 0;
        first = due_answers.size();
        head  = waiters[wq_head];
        case (mode)
            OP_RD_ACQ, OP_TRY_RD:
            begin
                if (!wr_held && wq_count == 0)
                begin
                    bump_readers();
                    answer(id, OUT_GRANTED, ERR_OK);
                end
                else if (mode == OP_TRY_RD)
                    answer(id, OUT_REFUSED, ERR_OK);
                else if (wq_count == QUEUE_DEPTH_DEF)
                    answer(id, OUT_REFUSED, ERR_QUEUE_FULL);
                else
                begin
                    push_waiter({1'b0, id});
                    answer(id, OUT_QUEUED, ERR_OK);
                end
            end
            OP_RD_REL:
            begin
                if (rd_count == 0)
                    answer(id, OUT_REFUSED, ERR_NOT_HELD);
                else
                begin
                    rd_count--;
                    if (rd_count != 0 || wq_count == 0)
                        answer(id, OUT_RELEASED, ERR_OK);
                    else if (!head[KIND_BIT])
                        answer(id, OUT_RELEASED, ERR_WRONG_KIND);
                    else
                    begin
                        drop_head();
                        wr_held = 1'b1;
                        answer(head[ID_BITS_DEF-1:0], OUT_WOKEN, ERR_OK);
                    end
                end
            end
            OP_WR_ACQ:
            begin
                if (rd_count == 0 && !wr_held)
                begin
                    wr_held = 1'b1;
                    answer(id, OUT_GRANTED, ERR_OK);
                end
                else if (wq_count == QUEUE_DEPTH_DEF)
                    answer(id, OUT_REFUSED, ERR_QUEUE_FULL);
                else
                begin
                    push_waiter({1'b1, id});
                    answer(id, OUT_QUEUED, ERR_OK);
                end
            end
            OP_WR_REL:
            begin
                if (!wr_held)
                    answer(id, OUT_REFUSED, ERR_NOT_HELD);
                else if (wq_count == 0)
                begin
                    wr_held = 1'b0;
                    answer(id, OUT_RELEASED, ERR_OK);
                end
                else if (head[KIND_BIT])
                begin
                    drop_head();
                    answer(head[ID_BITS_DEF-1:0], OUT_WOKEN, ERR_OK);
                end
                else
                begin
                    // Wake the run of readers up to the first writer, MAX_RESULTS at most.
                    while (wq_count != 0 && !waiters[wq_head][KIND_BIT] && woke < MAX_RESULTS)
                    begin
                        answer(waiters[wq_head][ID_BITS_DEF-1:0], OUT_WOKEN, ERR_OK);
                        drop_head();
                        bump_readers();
                        woke++;
                    end
                    wr_held = 1'b0;
                end
            end
            default: ;
        endcase
        if (due_answers.size() > first)
        begin
            tail_ans = due_answers.pop_back();
            tail_ans.last = 1'b1;
            due_answers.push_back(tail_ans);
        end
    endfunction

    // Offer one request, hold it until the transfer, then predict its answers.
    task automatic send_request(logic [MODE_W-1:0] mode, logic [ID_BITS_DEF-1:0] id);
        while (!feed_calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({id, mode});
        do
            @(posedge clk);
        while (!s_tready);
        apply_lock_request(mode, id);
    endtask

    // Pause the sender until every owed answer has arrived.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (due_answers.size() != 0);
    endtask

    // With a writer holding the lock, fill the queue with readers, push one
    // acquire past full, then release so the readers wake in one run.
    task automatic queue_burst();
        while (wq_count != QUEUE_DEPTH_DEF)
            send_request(OP_RD_ACQ, 6'($urandom_range(63)));
        send_request($urandom_range(1) ? OP_RD_ACQ : OP_WR_ACQ, 6'($urandom_range(63)));
        send_request(OP_WR_REL, 6'($urandom_range(63)));
    endtask

    // Mostly sensible requests for the current lock state, some raw noise.
    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return MODE_W'($urandom_range(7));
        if (wr_held)
            return r < 45 ? OP_WR_REL : r < 75 ? OP_RD_ACQ : r < 90 ? OP_WR_ACQ : OP_TRY_RD;
        if (rd_count != 0)
            return r < 50 ? OP_RD_REL : r < 65 ? OP_RD_ACQ : r < 80 ? OP_WR_ACQ :
                   r < 90 ? OP_TRY_RD : OP_WR_REL;
        return r < 45 ? OP_RD_ACQ : r < 70 ? OP_WR_ACQ : r < 80 ? OP_TRY_RD :
               r < 90 ? OP_RD_REL : OP_WR_REL;
    endfunction

    // Stimulus: opening script, a full-queue burst, then random traffic, then reader saturation.
    initial
    begin : stimulus
        answer_t fixed;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening_rows[i])
        begin
            send_request(opening_rows[i].mode, opening_rows[i].id);
            if (opening_rows[i].typed)
            begin
                // Swap the predicted answer for the one written in the row.
                void'(due_answers.pop_back());
                fixed = '{who: opening_rows[i].id, outcome: opening_rows[i].outcome,
                          error: opening_rows[i].error, last: 1'b1};
                due_answers.push_back(fixed);
            end
        end

        // Writer 0 holds the lock here: fill to full and wake the longest run.
        queue_burst();
        settle();

        for (int k = 0; k < GENERAL_ITEMS; k++)
        begin
            feed_calm = (k >= 60 && k < 140);
            if (wr_held && wq_count == 0 && rd_count == 0 && $urandom_range(9) == 0)
                queue_burst();
            else
                send_request(pick_mode(), 6'($urandom_range(63)));
        end
        feed_calm = 1'b0;

        // Release everything, then pile readers past the counter's top.
        for (int k = 0; k < 300 && (rd_count != 0 || wr_held); k++)
            send_request(wr_held ? OP_WR_REL : OP_RD_REL, 6'($urandom_range(63)));
        settle();
        repeat (SATURATE_ITEMS)
            send_request($urandom_range(1) ? OP_RD_ACQ : OP_TRY_RD, 6'($urandom_range(63)));
        send_request(OP_WR_ACQ, 6'($urandom_range(63)));
        repeat (3)
            send_request(OP_RD_REL, 6'($urandom_range(63)));

        s_tvalid <= 1'b0;
        while (due_answers.size() != 0)
            @(posedge clk);
        // Leave room for any stray result.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("PASS fifo_readers_writer_lock");
        else
            $display("FAIL fifo_readers_writer_lock");
        $finish;
    end

    // Receiver: check each result transfer, idle at random, stall once for long.
    initial
    begin : result_side
        answer_t got;
        answer_t want;
        int      seen;
        int      hold_left;
        bit      held_once;
        bit      calm;
        seen      = 0;
        hold_left = 0;
        held_once = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = '{who: m_tdata[5:0], outcome: outcome_t'(m_tdata[8:6]),
                        error: error_t'(m_tdata[10:9]), last: m_tlast};
                seen++;
                if (due_answers.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected result: who=%0d outcome=%0d error=%0d last=%0b",
                                 got.who, got.outcome, got.error, got.last);
                end
                else
                begin
                    want = due_answers.pop_front();
                    if (got.who != want.who || got.outcome != want.outcome ||
                        got.error != want.error || got.last != want.last)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display({"result mismatch: expected who=%0d outcome=%0d ",
                                      "error=%0d last=%0b, got who=%0d outcome=%0d ",
                                      "error=%0d last=%0b"},
                                     want.who, want.outcome, want.error, want.last,
                                     got.who, got.outcome, got.error, got.last);
                    end
                end
            end
            // Hold off once for a long stretch so the input side backs up.
            if (hold_left > 0)
                hold_left--;
            else if (seen >= 40 && !held_once)
            begin
                hold_left = HOLDOFF_LEN;
                held_once = 1'b1;
            end
            calm = (seen >= 150 && seen < 300);
            m_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    int stall_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("FAIL fifo_readers_writer_lock");
            $finish;
        end
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/frwl_pkg.sv
sv/frwl_front.sv
sv/frwl_back.sv
sv/fifo_readers_writer_lock.sv
tb/tb.sv
